>>> hw/rtl/fcsg_pkg.sv
// fcsg_pkg: shared types and constants of the filled circle span generator.
// No dependencies; used by fcsg_cmp, fcsg_seq and filled_circle_span_generator.
package fcsg_pkg;

  localparam logic [4:0] MAX_RADIUS = 5'd31;

  // request to the shared distance compare unit
  typedef struct packed {
    logic [5:0] col;   // trial column offset magnitude
    logic [4:0] row;   // row offset magnitude
    logic [4:0] rad;   // circle radius
  } cmp_req_t;

  // one span word as produced by the sequencer
  typedef struct packed {
    logic [7:0]  x;
    logic [7:0]  y;
    logic [5:0]  width;
    logic [15:0] color;
    logic        last;
  } span_t;

  // sequencer status, watched by the top level
  typedef struct packed {
    logic       busy;
    logic [4:0] row;
    logic [4:0] col;
    logic [4:0] rad;
  } seq_stat_t;

endpackage

>>> hw/rtl/fcsg_cmp.sv
// fcsg_cmp: shared compare unit, tests col^2 + row^2 <= rad^2.
// Depends on fcsg_pkg (cmp_req_t).
module fcsg_cmp
  import fcsg_pkg::*;
(
  input  cmp_req_t req,
  output logic     fits
);

  logic [11:0] col_sq;
  logic [9:0]  row_sq;
  logic [9:0]  rad_sq;
  logic [12:0] dist_sq;

  assign col_sq  = {6'd0, req.col} * {6'd0, req.col};
  assign row_sq  = {5'd0, req.row} * {5'd0, req.row};
  assign rad_sq  = {5'd0, req.rad} * {5'd0, req.rad};
  assign dist_sq = {1'b0, col_sq} + {3'd0, row_sq};
  assign fits    = (dist_sq <= {3'd0, rad_sq});

endmodule

>>> hw/rtl/fcsg_seq.sv
// fcsg_seq: row/column sequencer; walks the rows, grows the column offset
// through fcsg_cmp and hands out two span words per row. Depends on fcsg_pkg.
module fcsg_seq
  import fcsg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_center_x,
  input  logic [7:0]  in_center_y,
  input  logic [4:0]  in_radius,
  input  logic [15:0] in_fill_color,
  output cmp_req_t    cmp_req,
  input  logic        cmp_fits,
  output logic        span_valid,
  output span_t       span,
  input  logic        span_take,
  output seq_stat_t   stat
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_SEARCH  = 2'd1;
  localparam logic [1:0] S_EMIT_LO = 2'd2;
  localparam logic [1:0] S_EMIT_HI = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [4:0]  row_r, row_nxt;     // -dy
  logic [4:0]  col_r, col_nxt;     // -dx
  logic [4:0]  rad_r, rad_nxt;
  logic [7:0]  cx_r, cx_nxt;
  logic [7:0]  cy_r, cy_nxt;
  logic [15:0] color_r, color_nxt;

  assign in_stall = (state_r != S_IDLE);

  assign cmp_req.col = {1'b0, col_r} + 6'd1;
  assign cmp_req.row = row_r;
  assign cmp_req.rad = rad_r;

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    rad_nxt   = rad_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    color_nxt = color_r;
    span_valid  = 1'b0;
    span.x      = cx_r - {3'd0, col_r};
    span.y      = cy_r - {3'd0, row_r};
    span.width  = {col_r, 1'b0};
    span.color  = color_r;
    span.last   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rad_nxt   = (in_radius > MAX_RADIUS) ? MAX_RADIUS : in_radius;
          row_nxt   = rad_nxt;
          col_nxt   = 5'd0;
          cx_nxt    = in_center_x;
          cy_nxt    = in_center_y;
          color_nxt = in_fill_color;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // column offset only grows as the row offset shrinks
        if ((col_r < rad_r) && cmp_fits) begin
          col_nxt = col_r + 5'd1;
        end else begin
          state_nxt = S_EMIT_LO;
        end
      end
      S_EMIT_LO: begin
        span_valid = 1'b1;
        if (span_take) begin
          state_nxt = S_EMIT_HI;
        end
      end
      S_EMIT_HI: begin
        span_valid = 1'b1;
        span.y     = cy_r + {3'd0, row_r};
        span.last  = (row_r == 5'd0);
        if (span_take) begin
          if (row_r == 5'd0) begin
            state_nxt = S_IDLE;
          end else begin
            row_nxt   = row_r - 5'd1;
            state_nxt = S_SEARCH;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      row_r   <= 5'd0;
      col_r   <= 5'd0;
      rad_r   <= 5'd0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      rad_r   <= rad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    color_r <= color_nxt;
  end

  assign stat.busy = (state_r != S_IDLE);
  assign stat.row  = row_r;
  assign stat.col  = col_r;
  assign stat.rad  = rad_r;

endmodule

>>> hw/rtl/filled_circle_span_generator.sv
// filled_circle_span_generator: fills a circle as 2*(radius+1) horizontal spans.
// After a request word is taken, the first span word follows the column search of the
// first row and is registered in the output register. Each row steps its column search
// through the shared compare unit, then emits its upper and lower span words, which wait
// on the output register; the next request is taken once the last word is in that register.
// Reset (rst_n, sync, active low) idles the sequencer and empties the output.
module filled_circle_span_generator
  import fcsg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // request words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_center_x,
  input  logic [7:0]  in_center_y,
  input  logic [4:0]  in_radius,
  input  logic [15:0] in_fill_color,
  // span words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_span_x,
  output logic [7:0]  out_span_y,
  output logic [5:0]  out_span_width,
  output logic [15:0] out_span_color,
  output logic        out_last_span
);

  cmp_req_t  cmp_req;
  logic      cmp_fits;
  logic      span_valid;
  span_t     span;
  logic      span_take;
  seq_stat_t stat;

  logic      out_valid_r, out_valid_nxt;
  span_t     out_word_r, out_word_nxt;

  // shared compare unit: one trial column per cycle during the search
  fcsg_cmp u_cmp (
    .req  (cmp_req),
    .fits (cmp_fits)
  );

  // row walk, column search and span emission
  fcsg_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_center_x   (in_center_x),
    .in_center_y   (in_center_y),
    .in_radius     (in_radius),
    .in_fill_color (in_fill_color),
    .cmp_req       (cmp_req),
    .cmp_fits      (cmp_fits),
    .span_valid    (span_valid),
    .span          (span),
    .span_take     (span_take),
    .stat          (stat)
  );

  // output register: refilled when empty or when its word leaves this cycle,
  // so the sequencer keeps going while the consumer drains at full rate
  assign span_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (span_take) begin
      out_valid_nxt = span_valid;
      out_word_nxt  = span;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_span_x     = out_word_r.x;
  assign out_span_y     = out_word_r.y;
  assign out_span_width = out_word_r.width;
  assign out_span_color = out_word_r.color;
  assign out_last_span  = out_word_r.last;

`ifndef SYNTH
  // a taken request starts a busy sequence
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> stat.busy)
    else $error("sequencer not busy after request");

  // column and row offsets never pass the radius
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> (stat.col <= stat.rad) && (stat.row <= stat.rad))
    else $error("row or column offset beyond radius");

  // the final span word ends the sequence
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    span_valid && span_take && span.last |=> !stat.busy)
    else $error("sequencer busy after last span");

  // a span word is only produced while a request is in progress
  a_span_busy: assert property (@(posedge clk) disable iff (!rst_n)
    span_valid |-> stat.busy)
    else $error("span word while idle");
`endif

endmodule

>>> bench/filled_circle_span_generator_tb.sv
// filled_circle_span_generator_tb: self-checking bench for the circle span generator.
// Depends on fcsg_pkg (span_t, MAX_RADIUS) and filled_circle_span_generator.
// Predicts every span word per request and checks them in order under random idling.
module filled_circle_span_generator_tb
  import fcsg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PRINTED_MISMATCHES = 50;

  // clock and reset
  logic        clk;
  logic        rst_n = 1'b0;

  // request words; every input is known from time zero
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_center_x = '0;
  logic [7:0]  in_center_y = '0;
  logic [4:0]  in_radius = '0;
  logic [15:0] in_fill_color = '0;

  // span words
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_span_x;
  logic [7:0]  out_span_y;
  logic [5:0]  out_span_width;
  logic [15:0] out_span_color;
  logic        out_last_span;

  // spans still owed by the block, oldest first
  span_t       pending_spans[$];

  int          error_count = 0;
  int          span_count = 0;

  // idling knobs, percent of cycles
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  // long output hold-off: the test posts a length, the receiver counts it down
  int          hold_off_request = 0;
  int          hold_off_left = 0;

  filled_circle_span_generator u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_radius      (in_radius),
    .in_fill_color  (in_fill_color),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_span_x     (out_span_x),
    .out_span_y     (out_span_y),
    .out_span_width (out_span_width),
    .out_span_color (out_span_color),
    .out_last_span  (out_last_span)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Expected spans of one circle. For each row offset a (= -dy) from r down
  // to 0, pick the widest half-width b with b*b + a*a <= r*r, then the upper
  // row span, then the lower one. Row a = 0 is emitted twice; the second of
  // those carries last. Everything wraps mod 256, nothing is clipped.
  function automatic void predict_circle_spans(input logic [7:0]  cx,
                                               input logic [7:0]  cy,
                                               input logic [4:0]  r,
                                               input logic [15:0] color);
    int    rad;
    int    rr;
    int    b;
    span_t s;
    rad = r;
    if (rad > MAX_RADIUS) rad = MAX_RADIUS;  // saturation, unreachable at 5 bits
    rr = rad * rad;
    for (int a = rad; a >= 0; a--) begin
      b = rad;
      while (b > 0 && b * b + a * a > rr) b--;
      s.x     = 8'(int'(cx) - b);
      s.y     = 8'(int'(cy) - a);
      s.width = 6'(2 * b);
      s.color = color;
      s.last  = 1'b0;
      pending_spans.push_back(s);
      s.y     = 8'(int'(cy) + a);
      s.last  = (a == 0);
      pending_spans.push_back(s);
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (error_count < MAX_PRINTED_MISMATCHES)
      $display("MISMATCH span %0d: %s got %0h, want %0h", span_count, what, got, want);
    error_count++;
  endtask

  // Span checker: compare each accepted word with the oldest owed span.
  always @(posedge clk) begin
    span_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_spans.size() == 0) begin
        report_mismatch("unexpected word, x", out_span_x, 0);
      end else begin
        want = pending_spans.pop_front();
        if (out_span_x !== want.x)         report_mismatch("x", out_span_x, want.x);
        if (out_span_y !== want.y)         report_mismatch("y", out_span_y, want.y);
        if (out_span_width !== want.width) report_mismatch("width", out_span_width, want.width);
        if (out_span_color !== want.color) report_mismatch("color", out_span_color, want.color);
        if (out_last_span !== want.last)   report_mismatch("last", out_last_span, want.last);
      end
      span_count++;
    end
  end

  // Receiver: random stall, or a counted hold-off when one is posted.
  always @(posedge clk) begin
    if (hold_off_request != 0) begin
      hold_off_left = hold_off_request;
      hold_off_request = 0;
    end
    if (hold_off_left != 0) begin
      out_stall <= 1'b1;
      hold_off_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Send one request word. Valid drops only during an idle gap, so a
  // back-to-back word never sees valid lowered and raised in one step.
  task automatic send_circle(input logic [7:0] cx, input logic [7:0] cy,
                             input logic [4:0] r, input logic [15:0] color);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_center_x   <= cx;
    in_center_y   <= cy;
    in_radius     <= r;
    in_fill_color <= color;
    do @(posedge clk); while (in_stall);
    predict_circle_spans(cx, cy, r, color);
  endtask

  task automatic send_random_circle();
    send_circle(8'($urandom_range(255)), 8'($urandom_range(255)),
                5'($urandom_range(31)), 16'($urandom_range(16'hFFFF)));
  endtask

  // Stop offering, wait until every owed span is in, then wait on for stray words.
  task automatic wait_spans_drained();
    in_valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Corners: zero radius, full radius, wrap at every display edge, and
  // colors with alternating bit patterns.
  task automatic test_corner_circles();
    set_idling(0, 0);
    send_circle(8'd0,   8'd0,   5'd0,  16'h0000);
    send_circle(8'd255, 8'd255, 5'd0,  16'hFFFF);
    send_circle(8'd128, 8'd128, 5'd31, 16'hAAAA);
    send_circle(8'd0,   8'd0,   5'd31, 16'h5555);
    send_circle(8'd255, 8'd255, 5'd31, 16'hFFFF);
    send_circle(8'd0,   8'd255, 5'd1,  16'h0001);
    send_circle(8'd255, 8'd0,   5'd2,  16'h8000);
    send_circle(8'd3,   8'd250, 5'd5,  16'hF800);
    send_circle(8'd250, 8'd3,   5'd16, 16'h07E0);
    send_circle(8'd100, 8'd60,  5'd15, 16'h001F);
    send_circle(8'd1,   8'd1,   5'd30, 16'h1234);
    send_circle(8'd127, 8'd200, 5'd7,  16'hFEDC);
    wait_spans_drained();
  endtask

  task automatic test_random_circles(input int count, input int send_pct,
                                     input int stall_pct);
    set_idling(send_pct, stall_pct);
    repeat (count) send_random_circle();
    wait_spans_drained();
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so
  // the output and sequencer fill and the request side must stall.
  task automatic test_output_hold_off();
    set_idling(0, 0);
    hold_off_request = 600;
    repeat (8) send_random_circle();
    wait_spans_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_circles();
    test_random_circles(90, 0, 0);
    test_random_circles(90, 77, 0);
    test_random_circles(90, 0, 77);
    test_random_circles(90, 11, 11);
    test_output_hold_off();

    wait_spans_drained();
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
